@@ design/bpd_pkg.sv @@
// bpd_pkg: shared types, codes and constants for the button press duration classifier
// no dependencies; imported by every module and interface of the block

package bpd_pkg;

  // tick count width; the count advances once per tick item and wraps
  localparam int TIME_WIDTH = 32;

  localparam int HOLD_WIDTH     = 20;
  localparam int DEBOUNCE_WIDTH = 8;
  localparam int HOLD3_WIDTH    = HOLD_WIDTH + 2;
  localparam int CMP_WIDTH      = (TIME_WIDTH > HOLD3_WIDTH) ? TIME_WIDTH : HOLD3_WIDTH;

  // config port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = HOLD_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_HIGH    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_TICKS     = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS = 2'd2;

  localparam logic                      RST_ACTIVE_HIGH    = 1'b1;
  localparam logic [HOLD_WIDTH-1:0]     RST_HOLD_TICKS     = 20'd1000;
  localparam logic [DEBOUNCE_WIDTH-1:0] RST_DEBOUNCE_TICKS = 8'd4;

  // item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_IDLE      = 2'd0,
    STATUS_PRESSED   = 2'd1,
    STATUS_HELD      = 2'd2,
    STATUS_LONG_HELD = 2'd3
  } status_t;

  typedef struct packed {
    logic                      active_high;
    logic [HOLD_WIDTH-1:0]     hold_ticks;
    logic [DEBOUNCE_WIDTH-1:0] debounce_ticks;
  } cfg_t;

endpackage

@@ design/bpd_intf.sv @@
// bpd_intf: valid/ready channel interfaces for item, result and config transactions
// depends on bpd_pkg

interface bpd_req_if import bpd_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  logic pin_level;

  modport source (output valid, kind, pin_level, input ready);
  modport sink   (input valid, kind, pin_level, output ready);
endinterface

interface bpd_rsp_if import bpd_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  logic    any_event;

  modport source (output valid, status, any_event, input ready);
  modport sink   (input valid, status, any_event, output ready);
endinterface

interface bpd_cfg_if import bpd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/bpd_cfg_regs.sv @@
// bpd_cfg_regs: configuration register file written over the config channel
// depends on bpd_pkg and bpd_cfg_if

module bpd_cfg_regs import bpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bpd_cfg_if.sink   cfg,
  output cfg_t      regs
);

  cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_ACTIVE_HIGH:    regs_next.active_high    = cfg.data[0];
        REG_HOLD_TICKS:     regs_next.hold_ticks     = cfg.data[HOLD_WIDTH-1:0];
        REG_DEBOUNCE_TICKS: regs_next.debounce_ticks = cfg.data[DEBOUNCE_WIDTH-1:0];
        default:            regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.active_high    <= RST_ACTIVE_HIGH;
      regs.hold_ticks     <= RST_HOLD_TICKS;
      regs.debounce_ticks <= RST_DEBOUNCE_TICKS;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

@@ design/bpd_core.sv @@
// bpd_core: tick counter, edge debounce, press timing and status latch
// depends on bpd_pkg; fed by the top level's input register

module bpd_core import bpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    regs,
  input  logic    item_go,
  input  logic    item_kind,
  input  logic    item_level,
  output status_t read_status
);

  logic [TIME_WIDTH-1:0]     tick_now;
  logic [TIME_WIDTH-1:0]     press_start;
  status_t                   latched_status;
  logic                      edge_armed;
  logic [DEBOUNCE_WIDTH-1:0] debounce_left;
  logic                      previous_level;

  logic [TIME_WIDTH-1:0]     tick_now_next;
  logic [TIME_WIDTH-1:0]     press_start_next;
  status_t                   latched_status_next;
  logic                      edge_armed_next;
  logic [DEBOUNCE_WIDTH-1:0] debounce_left_next;
  logic                      previous_level_next;

  logic [TIME_WIDTH-1:0]  tick_inc;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [HOLD3_WIDTH-1:0] hold3;
  logic [CMP_WIDTH-1:0]   elapsed_ext;
  logic [CMP_WIDTH-1:0]   hold_ext;
  logic [CMP_WIDTH-1:0]   hold3_ext;
  status_t                classified;

  assign tick_inc    = tick_now + TIME_WIDTH'(1);
  assign elapsed     = tick_inc - press_start;
  assign hold3       = {1'b0, regs.hold_ticks, 1'b0} + HOLD3_WIDTH'(regs.hold_ticks);
  assign elapsed_ext = CMP_WIDTH'(elapsed);
  assign hold_ext    = CMP_WIDTH'(regs.hold_ticks);
  assign hold3_ext   = CMP_WIDTH'(hold3);

  always_comb begin
    if (elapsed_ext >= hold3_ext) begin
      classified = STATUS_LONG_HELD;
    end else if (elapsed_ext >= hold_ext) begin
      classified = STATUS_HELD;
    end else begin
      classified = STATUS_PRESSED;
    end
  end

  assign read_status = latched_status;

  always_comb begin
    tick_now_next       = tick_now;
    press_start_next    = press_start;
    latched_status_next = latched_status;
    edge_armed_next     = edge_armed;
    debounce_left_next  = debounce_left;
    previous_level_next = previous_level;
    if (item_go) begin
      if (item_kind == KIND_READ) begin
        latched_status_next = STATUS_IDLE;
      end else begin
        tick_now_next       = tick_inc;
        previous_level_next = item_level;
        if (edge_armed) begin
          if (item_level != previous_level) begin
            debounce_left_next = regs.debounce_ticks;
            edge_armed_next    = 1'b0;
          end
        end else if (debounce_left <= DEBOUNCE_WIDTH'(1)) begin
          // countdown done: qualifying sample
          debounce_left_next = '0;
          edge_armed_next    = 1'b1;
          if (item_level == regs.active_high) begin
            press_start_next = tick_inc;
          end else begin
            latched_status_next = classified;
          end
        end else begin
          debounce_left_next = debounce_left - DEBOUNCE_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now       <= '0;
      press_start    <= '0;
      latched_status <= STATUS_IDLE;
      edge_armed     <= 1'b1;
      debounce_left  <= '0;
      previous_level <= ~RST_ACTIVE_HIGH;
    end else begin
      tick_now       <= tick_now_next;
      press_start    <= press_start_next;
      latched_status <= latched_status_next;
      edge_armed     <= edge_armed_next;
      debounce_left  <= debounce_left_next;
      previous_level <= previous_level_next;
    end
  end

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    item_go && item_kind == KIND_READ |=> latched_status == STATUS_IDLE)
    else $error("status not cleared after read");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    item_go && item_kind == KIND_TICK |=> tick_now == $past(tick_now) + TIME_WIDTH'(1))
    else $error("tick count did not advance");

  a_edge_disarms: assert property (@(posedge clk) disable iff (rst)
    item_go && item_kind == KIND_TICK && edge_armed && item_level != previous_level
    |=> !edge_armed)
    else $error("edge did not start debounce");

endmodule

@@ design/bpd_out_reg.sv @@
// bpd_out_reg: result register on the response channel
// depends on bpd_pkg and bpd_rsp_if

module bpd_out_reg import bpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  status_t  load_status,
  output logic     free,
  bpd_rsp_if.source rsp
);

  logic    valid;
  status_t status;

  assign free          = !valid || rsp.ready;
  assign rsp.valid     = valid;
  assign rsp.status    = status;
  assign rsp.any_event = (status != STATUS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= load_status;
    end
  end

endmodule

@@ design/button_press_duration_classifier.sv @@
// button_press_duration_classifier: top level
// one item a cycle while no read waits: input register, then the core's single pass, then the result
// register; a read waits in the input register only while the result register is full
// reset (rst, synchronous) empties both registers and clears tick count, press time and
// status, arms edge detection and loads the register reset values; no clearing pass
// depends on bpd_pkg, bpd_intf, bpd_cfg_regs, bpd_core and bpd_out_reg

module button_press_duration_classifier import bpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bpd_req_if.sink   req,
  bpd_rsp_if.source rsp,
  bpd_cfg_if.sink   cfg
);

  cfg_t    regs;
  status_t read_status;

  // input register
  logic in_valid;
  logic in_kind;
  logic in_level;

  logic out_free;
  logic item_go;
  logic out_load;

  // ticks always pass; a read needs room in the result register
  assign item_go  = in_valid && (in_kind == KIND_TICK || out_free);
  assign out_load = item_go && in_kind == KIND_READ;
  assign req.ready = !in_valid || item_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_kind  <= req.kind;
      in_level <= req.pin_level;
    end
  end

  bpd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .item_go     (item_go),
    .item_kind   (in_kind),
    .item_level  (in_level),
    .read_status (read_status)
  );

  bpd_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (out_load),
    .load_status (read_status),
    .free        (out_free),
    .rsp         (rsp)
  );

  // a held read only while the result register is blocked
  a_read_waits_on_output: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_kind == KIND_READ && !item_go |-> rsp.valid && !rsp.ready)
    else $error("read stalled without a blocked result");

  // a tick transaction never stalls in the input register
  a_tick_never_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_kind == KIND_TICK |-> item_go)
    else $error("tick stalled");

  // a result appears after a read passes the core
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> rsp.valid)
    else $error("read produced no result");

endmodule
